/* src/vwcp_pkg.sv */
// Shared constants and types for the variable-width code packer.
package vwcp_pkg;

  localparam int WORD_BITS     = 16;
  localparam int MAX_CODE_BITS = 16;

  localparam int CODE_W  = 16;
  localparam int WIDTH_W = 5;
  localparam int CW_W    = $clog2(MAX_CODE_BITS + 1);
  localparam int CNT_W   = $clog2(WORD_BITS + MAX_CODE_BITS);
  localparam int ACC_W   = WORD_BITS - 1;
  localparam int TOT_W   = WORD_BITS - 1 + MAX_CODE_BITS;
  localparam int IN_TDATA_W  = ((CODE_W + WIDTH_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WORD_BITS + 7) / 8) * 8;
  localparam int QCNT_W  = 2;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } res_t;

endpackage

/* src/variable_width_code_packer_top.sv */
// Variable-width code packer: MSB-first packing of 1..16-bit codes into 16-bit words.
// A code is registered in the input stage, then its words in the output queue that drives out_*.
// Throughput: one code per cycle while out_tready stays high; a flush that yields two words
// holds in_tready low while the output queue drains.
// Reset (rst_n low, synchronous) empties the accumulator, the input stage and the
// two-entry output queue.
module variable_width_code_packer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vwcp_pkg::IN_TDATA_W-1:0]  in_tdata,  // code_value, code_width, zero pad
  input  logic                             in_tlast,  // flush
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vwcp_pkg::OUT_TDATA_W-1:0] out_tdata, // out_word
  output logic                             out_tlast  // last_word
);

  logic                                s1_valid_r, s1_valid_nxt;
  logic [vwcp_pkg::CODE_W-1:0]         s1_value_r, s1_value_nxt;
  logic [vwcp_pkg::WIDTH_W-1:0]        s1_width_r, s1_width_nxt;
  logic                                s1_flush_r, s1_flush_nxt;

  logic [vwcp_pkg::ACC_W-1:0]          acc_r, acc_nxt;
  logic [vwcp_pkg::CNT_W-1:0]          cnt_r, cnt_nxt;

  vwcp_pkg::res_t                      q0_r, q0_nxt, q1_r, q1_nxt;
  logic [vwcp_pkg::QCNT_W-1:0]         qcnt_r, qcnt_nxt;

  logic                                pop, fire, in_fire;
  logic [vwcp_pkg::CW_W-1:0]           w;
  logic [vwcp_pkg::MAX_CODE_BITS-1:0]  code;
  logic [vwcp_pkg::TOT_W-1:0]          total;
  logic [vwcp_pkg::CNT_W-1:0]          cnt_sum, rem;
  logic                                has_full;
  logic [vwcp_pkg::ACC_W-1:0]          rem_bits;
  logic [vwcp_pkg::WORD_BITS-1:0]      full_word, pad_word;
  logic [vwcp_pkg::ACC_W+vwcp_pkg::WORD_BITS-1:0] pad_ext;
  vwcp_pkg::res_t                      r0, r1;
  logic [vwcp_pkg::QCNT_W-1:0]         nres;

  assign pop        = out_tvalid && out_tready;
  assign fire       = s1_valid_r &&
                      ((qcnt_r == '0) || ((qcnt_r == vwcp_pkg::QCNT_W'(1)) && pop));
  assign in_tready  = !s1_valid_r || fire;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = (qcnt_r != '0);
  assign out_tdata  = vwcp_pkg::OUT_TDATA_W'(q0_r.word);
  assign out_tlast  = q0_r.last;

  always_comb begin
    w = (s1_width_r > vwcp_pkg::WIDTH_W'(vwcp_pkg::MAX_CODE_BITS))
        ? vwcp_pkg::CW_W'(vwcp_pkg::MAX_CODE_BITS)
        : vwcp_pkg::CW_W'(s1_width_r);
    code = s1_value_r[vwcp_pkg::MAX_CODE_BITS-1:0]
           & ~({vwcp_pkg::MAX_CODE_BITS{1'b1}} << w);
    total    = (vwcp_pkg::TOT_W'(acc_r) << w) | vwcp_pkg::TOT_W'(code);
    cnt_sum  = cnt_r + vwcp_pkg::CNT_W'(w);
    has_full = (cnt_sum >= vwcp_pkg::CNT_W'(vwcp_pkg::WORD_BITS));
    rem      = has_full ? (cnt_sum - vwcp_pkg::CNT_W'(vwcp_pkg::WORD_BITS)) : cnt_sum;
    rem_bits = vwcp_pkg::ACC_W'(total) & ~({vwcp_pkg::ACC_W{1'b1}} << rem);
    full_word = vwcp_pkg::WORD_BITS'(total >> rem);
    pad_ext   = {rem_bits, {vwcp_pkg::WORD_BITS{1'b0}}} >> rem;
    pad_word  = pad_ext[vwcp_pkg::WORD_BITS-1:0];

    r0   = '{word: full_word, last: 1'b0};
    r1   = '{word: pad_word, last: 1'b1};
    nres = '0;
    if (has_full) begin
      if (s1_flush_r && (rem != '0)) begin
        nres = vwcp_pkg::QCNT_W'(2);
      end else begin
        r0.last = s1_flush_r;
        nres    = vwcp_pkg::QCNT_W'(1);
      end
    end else if (s1_flush_r && (rem != '0)) begin
      r0   = r1;
      nres = vwcp_pkg::QCNT_W'(1);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_value_nxt = s1_value_r;
    s1_width_nxt = s1_width_r;
    s1_flush_nxt = s1_flush_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
      s1_value_nxt = in_tdata[vwcp_pkg::CODE_W-1:0];
      s1_width_nxt = in_tdata[vwcp_pkg::CODE_W+vwcp_pkg::WIDTH_W-1:vwcp_pkg::CODE_W];
      s1_flush_nxt = in_tlast;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end

    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    if (fire) begin
      acc_nxt = s1_flush_r ? '0 : rem_bits;
      cnt_nxt = s1_flush_r ? '0 : rem;
    end

    q0_nxt   = q0_r;
    q1_nxt   = q1_r;
    qcnt_nxt = qcnt_r;
    if (fire) begin
      q0_nxt   = r0;
      q1_nxt   = r1;
      qcnt_nxt = nres;
    end else if (pop) begin
      q0_nxt   = q1_r;
      qcnt_nxt = qcnt_r - vwcp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      acc_r      <= '0;
      cnt_r      <= '0;
      qcnt_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      qcnt_r     <= qcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_value_r <= s1_value_nxt;
    s1_width_r <= s1_width_nxt;
    s1_flush_r <= s1_flush_nxt;
    q0_r       <= q0_nxt;
    q1_r       <= q1_nxt;
  end

`ifndef NO_ASSERTIONS
  a_qcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcnt_r <= vwcp_pkg::QCNT_W'(2))
    else $error("output queue overfilled");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < vwcp_pkg::CNT_W'(vwcp_pkg::WORD_BITS))
    else $error("pending bit count reached a full word");

  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    fire && s1_flush_r |=> (cnt_r == '0) && (acc_r == '0))
    else $error("flush left bits pending");

  a_last_is_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> qcnt_r == vwcp_pkg::QCNT_W'(1))
    else $error("last word not at queue tail");
`endif

endmodule

/* dv/variable_width_code_packer_top_tb.sv */
// Self-checking testbench for the variable-width code packer: directed table, random codes.
`timescale 1ns / 100ps

module variable_width_code_packer_top_tb;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int RAND_PER_PHASE = 420;
  localparam int DRAIN_CYCLES   = 20;
  localparam int DIR_ROWS       = 23;
  localparam int PREDICT        = -1;
  localparam vwcp_pkg::res_t NO_WORD = '0;

  typedef struct {
    logic [vwcp_pkg::CODE_W-1:0]  code;
    logic [vwcp_pkg::WIDTH_W-1:0] width;
    logic                         flush;
    int                           n_typed;
    vwcp_pkg::res_t               r0;
    vwcp_pkg::res_t               r1;
  } code_row_t;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [vwcp_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;  // code_value, code_width, zero pad
  logic                             in_tlast   = 1'b0;  // flush
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [vwcp_pkg::OUT_TDATA_W-1:0] out_tdata;  // out_word
  logic                             out_tlast;  // last_word

  code_row_t      dir_rows [DIR_ROWS];
  code_row_t      code_notes [$];
  vwcp_pkg::res_t pending_words [$];
  logic [31:0]    pend_acc = '0;
  int unsigned    pend_cnt = 0;
  int             mismatch_count = 0;
  int             cycle_count = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;

  variable_width_code_packer_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pack_code(input logic [vwcp_pkg::CODE_W-1:0] code,
                                   input logic [vwcp_pkg::WIDTH_W-1:0] width,
                                   input logic flush, output vwcp_pkg::res_t words [2]);
    int unsigned w;
    int          n;
    logic [31:0] masked;
    w = (width > vwcp_pkg::MAX_CODE_BITS) ? vwcp_pkg::MAX_CODE_BITS : width;
    masked = {16'h0, code} & ((32'h1 << w) - 32'h1);
    pend_acc = (pend_acc << w) | masked;
    pend_cnt = pend_cnt + w;
    n = 0;
    words[0] = NO_WORD;
    words[1] = NO_WORD;
    while (pend_cnt >= vwcp_pkg::WORD_BITS) begin
      pend_cnt = pend_cnt - vwcp_pkg::WORD_BITS;
      words[n].word = vwcp_pkg::WORD_BITS'(pend_acc >> pend_cnt);
      words[n].last = 1'b0;
      pend_acc = pend_acc & ((32'h1 << pend_cnt) - 32'h1);
      n++;
    end
    if (flush) begin
      if (pend_cnt > 0) begin
        words[n].word = vwcp_pkg::WORD_BITS'(pend_acc << (vwcp_pkg::WORD_BITS - pend_cnt));
        words[n].last = 1'b1;
        pend_acc = '0;
        pend_cnt = 0;
        n++;
      end else if (n > 0) begin
        words[n-1].last = 1'b1;
      end
    end
    return n;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    vwcp_pkg::res_t got;
    vwcp_pkg::res_t exp;
    vwcp_pkg::res_t words [2];
    code_row_t      note;
    int             n;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.word = out_tdata[vwcp_pkg::WORD_BITS-1:0];
        got.last = out_tlast;
        if (pending_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word %h last %b", got.word, got.last);
        end else begin
          exp = pending_words.pop_front();
          if (got !== exp) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("word mismatch: expected %h last %b, got %h last %b",
                       exp.word, exp.last, got.word, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        note = code_notes.pop_front();
        n = pack_code(in_tdata[vwcp_pkg::CODE_W-1:0],
                      in_tdata[vwcp_pkg::CODE_W+vwcp_pkg::WIDTH_W-1:vwcp_pkg::CODE_W],
                      in_tlast, words);
        if (note.n_typed == PREDICT) begin
          for (int i = 0; i < n; i++) pending_words.push_back(words[i]);
        end else begin
          if (note.n_typed > 0) pending_words.push_back(note.r0);
          if (note.n_typed > 1) pending_words.push_back(note.r1);
        end
      end
    end
  end

  task automatic drive_code(input code_row_t row);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    code_notes.push_back(row);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(vwcp_pkg::IN_TDATA_W-vwcp_pkg::CODE_W-vwcp_pkg::WIDTH_W){1'b0}},
                  row.width, row.code};
    in_tlast  <= row.flush;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    code_row_t row;
    int        r;
    dir_rows = '{
      '{16'hFFFF, 5'd16, 1'b0, 1, '{16'hFFFF, 1'b0}, NO_WORD},
      '{16'h0000, 5'd16, 1'b1, 1, '{16'h0000, 1'b1}, NO_WORD},
      '{16'h1234, 5'd0,  1'b1, 0, NO_WORD, NO_WORD},
      '{16'h0001, 5'd1,  1'b1, 1, '{16'h8000, 1'b1}, NO_WORD},
      '{16'hABCD, 5'd31, 1'b0, 1, '{16'hABCD, 1'b0}, NO_WORD},
      '{16'h5555, 5'd17, 1'b0, 1, '{16'h5555, 1'b0}, NO_WORD},
      '{16'h0007, 5'd3,  1'b0, 0, NO_WORD, NO_WORD},
      '{16'hFFFF, 5'd16, 1'b1, 2, '{16'hFFFF, 1'b0}, '{16'hE000, 1'b1}},
      '{16'hFFF0, 5'd4,  1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'hFFFF, 5'd0,  1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h0155, 5'd9,  1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h02AA, 5'd10, 1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h8000, 5'd16, 1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h3FFF, 5'd15, 1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h0000, 5'd2,  1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'hFFFF, 5'd8,  1'b1, PREDICT, NO_WORD, NO_WORD},
      '{16'h0001, 5'd1,  1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h7FFF, 5'd15, 1'b1, 1, '{16'hFFFF, 1'b1}, NO_WORD},
      '{16'h0F0F, 5'd12, 1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h00FF, 5'd20, 1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'h0000, 5'd0,  1'b1, PREDICT, NO_WORD, NO_WORD},
      '{16'hFFFF, 5'd16, 1'b0, PREDICT, NO_WORD, NO_WORD},
      '{16'hC3C3, 5'd13, 1'b1, PREDICT, NO_WORD, NO_WORD}
    };
    send_idle_pct = 15;
    recv_idle_pct = 50;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (dir_rows[i]) drive_code(dir_rows[i]);
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        r = $urandom_range(99);
        row.code    = vwcp_pkg::CODE_W'($urandom);
        row.width   = (r < 4) ? 5'd0 :
                      (r < 10) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16, 1));
        row.flush   = ($urandom_range(15) == 0);
        row.n_typed = PREDICT;
        row.r0      = NO_WORD;
        row.r1      = NO_WORD;
        drive_code(row);
      end
    end
    in_tvalid <= 1'b0;
    while (pending_words.size() != 0 || code_notes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      mismatch_count += pending_words.size();
      if (mismatch_count <= 10)
        $display("%0d expected words never arrived", pending_words.size());
    end
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
